>>> rtl/core/multiport_round_robin_burst_mux_unit_assert.svh
// Assertion macros used by the back end of the round-robin burst mux.
`ifndef MULTIPORT_ROUND_ROBIN_BURST_MUX_UNIT_ASSERT_SVH
`define MULTIPORT_ROUND_ROBIN_BURST_MUX_UNIT_ASSERT_SVH

// Checks a condition at every rising clock edge outside reset.
`define MRBM_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define MRBM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mrbm_pkg.sv
// Shared types, widths and codes of the round-robin burst mux.
package mrbm_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int MST_ID_W   = 3;
	localparam int PORT_ID_W  = 1;
	localparam int LEN_W      = 8;

	localparam int DEF_NUM_MASTERS = 8;
	localparam int DEF_NUM_PORTS   = 2;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [REQ_TYPE_W-1:0] REQ_MASTER = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_ARB    = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_BEAT   = 2'd2;

	localparam logic RES_GRANT = 1'b0;
	localparam logic RES_BEAT  = 1'b1;

	typedef enum logic [1:0] {
		CMD_REQ,
		CMD_ARB,
		CMD_BEAT
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARB,
		ST_FLUSH
	} back_state_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [MST_ID_W-1:0]   master_id;
		logic                  is_write;
		logic [LEN_W-1:0]      burst_len;
		logic [PORT_ID_W-1:0]  port_id;
	} cmd_t;

endpackage

>>> rtl/core/mrbm_cmd_if.sv
// Request channel carrying one input item per handshake.
interface mrbm_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [mrbm_pkg::REQ_TYPE_W-1:0]     req_type;
	logic [mrbm_pkg::MST_ID_W-1:0]       master_id;
	logic                                is_write;
	logic [mrbm_pkg::LEN_W-1:0]          burst_len;
	logic [mrbm_pkg::PORT_ID_W-1:0]      port_id;

	modport source (
		output valid, req_type, master_id, is_write, burst_len, port_id,
		input  ready
	);
	modport sink (
		input  valid, req_type, master_id, is_write, burst_len, port_id,
		output ready
	);
endinterface

>>> rtl/core/mrbm_rsp_if.sv
// Result channel carrying one grant or beat acknowledge per handshake.
interface mrbm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                result_kind;
	logic [mrbm_pkg::PORT_ID_W-1:0]      port_out;
	logic [mrbm_pkg::MST_ID_W-1:0]       master_out;
	logic                                write_out;
	logic [mrbm_pkg::LEN_W-1:0]          beat_count;
	logic                                burst_done;
	logic                                last_result;

	modport source (
		output valid, result_kind, port_out, master_out, write_out, beat_count,
		       burst_done, last_result,
		input  ready
	);
	modport sink (
		input  valid, result_kind, port_out, master_out, write_out, beat_count,
		       burst_done, last_result,
		output ready
	);
endinterface

>>> rtl/core/mrbm_front.sv
// Front end: accepts requests, decodes and filters them, and queues commands.
module mrbm_front #(
	parameter int NUM_MASTERS = mrbm_pkg::DEF_NUM_MASTERS,
	parameter int NUM_PORTS   = mrbm_pkg::DEF_NUM_PORTS
) (
	input  logic              clk,
	input  logic              arst_n,
	mrbm_cmd_if.sink          cmd,
	output logic              q_valid,
	output mrbm_pkg::cmd_t    q_cmd,
	input  logic              q_pop
);

	localparam int Depth = mrbm_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	mrbm_pkg::cmd_t  entry_q [Depth];
	mrbm_pkg::cmd_t  dec;
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            keep;
	logic            push;

	// Unknown request types and out-of-range ids are consumed here.
	always_comb begin
		keep          = 1'b1;
		dec.kind      = mrbm_pkg::CMD_REQ;
		dec.master_id = cmd.master_id;
		dec.is_write  = cmd.is_write;
		dec.burst_len = cmd.burst_len;
		dec.port_id   = cmd.port_id;
		unique case (cmd.req_type)
			mrbm_pkg::REQ_MASTER: begin
				dec.kind = mrbm_pkg::CMD_REQ;
				keep     = int'(cmd.master_id) < NUM_MASTERS;
			end
			mrbm_pkg::REQ_ARB: begin
				dec.kind = mrbm_pkg::CMD_ARB;
			end
			mrbm_pkg::REQ_BEAT: begin
				dec.kind = mrbm_pkg::CMD_BEAT;
				keep     = int'(cmd.port_id) < NUM_PORTS;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (count_q != CntW'(Depth));
	assign push      = cmd.valid && cmd.ready && keep;
	assign q_valid   = (count_q != '0);
	assign q_cmd     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

endmodule

>>> rtl/core/mrbm_back.sv
// Back end: request table, per-port round-robin arbitration, beats and results.
module mrbm_back #(
	parameter int NUM_MASTERS = mrbm_pkg::DEF_NUM_MASTERS,
	parameter int NUM_PORTS   = mrbm_pkg::DEF_NUM_PORTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_data,
	input  logic              q_valid,
	input  mrbm_pkg::cmd_t    q_cmd,
	output logic              q_pop,
	mrbm_rsp_if.source        rsp
);

	`include "multiport_round_robin_burst_mux_unit_assert.svh"

	localparam int MW    = $clog2(NUM_MASTERS);
	localparam int PW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int LW    = mrbm_pkg::LEN_W;
	localparam int Half  = NUM_MASTERS / 2;

	mrbm_pkg::back_state_t state_q, state_d;

	logic                   static_q;
	logic [NUM_MASTERS-1:0] pending_q;
	logic [NUM_MASTERS-1:0] granted_q;
	logic [NUM_MASTERS-1:0] req_write_q;
	logic [LW-1:0]          req_beats_q [NUM_MASTERS];
	logic [NUM_PORTS-1:0]   port_busy_q;
	logic [NUM_PORTS-1:0]   port_write_q;
	logic [MW-1:0]          port_owner_q [NUM_PORTS];
	logic [LW-1:0]          port_len_q [NUM_PORTS];
	logic [LW-1:0]          beats_done_q [NUM_PORTS];
	logic [MW-1:0]          rr_ptr_q [NUM_PORTS];
	logic [PW-1:0]          port_q;

	logic                   hold_v_q;
	logic                   hold_kind_q;
	logic [PW-1:0]          hold_port_q;
	logic [MW-1:0]          hold_mst_q;
	logic                   hold_wr_q;
	logic [LW-1:0]          hold_cnt_q;
	logic                   hold_done_q;

	logic                   out_v_q;
	logic                   out_kind_q;
	logic [PW-1:0]          out_port_q;
	logic [MW-1:0]          out_mst_q;
	logic                   out_wr_q;
	logic [LW-1:0]          out_cnt_q;
	logic                   out_done_q;
	logic                   out_last_q;

	logic [MW-1:0]          cmd_mst;
	logic [PW-1:0]          cmd_port;
	logic [NUM_MASTERS-1:0] map_hit;
	logic [NUM_MASTERS-1:0] elig;
	logic [NUM_MASTERS-1:0] hi_mask;
	logic [NUM_MASTERS-1:0] elig_hi;
	logic [MW-1:0]          ptr;
	logic [MW-1:0]          pick;
	logic [MW-1:0]          next_ptr;
	logic                   found;
	logic [LW-1:0]          sel_len;
	logic                   sel_wr;
	logic                   port_free;
	logic                   b_busy;
	logic [MW-1:0]          b_owner;
	logic [LW:0]            b_cnt;
	logic                   b_fin;
	logic                   out_free;
	logic                   grant_cand;

	logic                   do_req;
	logic                   do_grant;
	logic                   do_beat;
	logic                   arb_start;
	logic                   arb_adv;
	logic                   hold_to_out;
	logic                   out_last;

	function automatic logic [MW-1:0] lowest(input logic [NUM_MASTERS-1:0] v);
		logic [MW-1:0] idx;
		idx = '0;
		for (int i = NUM_MASTERS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = MW'(i);
			end
		end
		return idx;
	endfunction

	assign cmd_mst  = MW'(q_cmd.master_id);
	assign cmd_port = PW'(q_cmd.port_id);

	// Static mode folds the upper half of the masters onto the lower half.
	for (genvar g = 0; g < NUM_MASTERS; g++) begin : g_map
		localparam int Norm    = (g >= Half) ? g - Half : g;
		localparam int MapPort = Norm % NUM_PORTS;
		assign map_hit[g] = (port_q == PW'(MapPort));
	end

	assign ptr  = rr_ptr_q[port_q];
	assign elig = pending_q & ~granted_q & (static_q ? map_hit : {NUM_MASTERS{1'b1}});

	always_comb begin
		for (int i = 0; i < NUM_MASTERS; i++) begin
			hi_mask[i] = (i >= int'(ptr));
		end
	end

	// Round robin: first eligible master at or after the pointer, else wrap.
	assign elig_hi   = elig & hi_mask;
	assign pick      = (|elig_hi) ? lowest(elig_hi) : lowest(elig);
	assign found     = |elig;
	assign next_ptr  = (pick == MW'(NUM_MASTERS - 1)) ? '0 : pick + MW'(1);
	assign sel_len   = req_beats_q[pick];
	assign sel_wr    = req_write_q[pick];
	assign port_free = !port_busy_q[port_q];
	assign grant_cand = port_free && found;

	assign b_busy  = port_busy_q[cmd_port];
	assign b_owner = port_owner_q[cmd_port];
	assign b_cnt   = {1'b0, beats_done_q[cmd_port]} + (LW + 1)'(1);
	assign b_fin   = b_cnt >= {1'b0, port_len_q[cmd_port]};

	assign out_free = !out_v_q || rsp.ready;

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		do_req      = 1'b0;
		do_grant    = 1'b0;
		do_beat     = 1'b0;
		arb_start   = 1'b0;
		arb_adv     = 1'b0;
		hold_to_out = 1'b0;
		out_last    = 1'b0;
		unique case (state_q)
			mrbm_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.kind)
						mrbm_pkg::CMD_REQ: begin
							do_req = !pending_q[cmd_mst];
						end
						mrbm_pkg::CMD_ARB: begin
							arb_start = 1'b1;
							state_d   = mrbm_pkg::ST_ARB;
						end
						mrbm_pkg::CMD_BEAT: begin
							if (b_busy) begin
								do_beat = 1'b1;
								state_d = mrbm_pkg::ST_FLUSH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			mrbm_pkg::ST_ARB: begin
				// A grant waits only when the previous one cannot move on.
				if (!(grant_cand && hold_v_q && !out_free)) begin
					arb_adv = 1'b1;
					if (grant_cand) begin
						do_grant    = 1'b1;
						hold_to_out = hold_v_q;
					end
					if (port_q == PW'(NUM_PORTS - 1)) begin
						state_d = mrbm_pkg::ST_FLUSH;
					end
				end
			end
			mrbm_pkg::ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = mrbm_pkg::ST_IDLE;
				end else if (out_free) begin
					hold_to_out = 1'b1;
					out_last    = 1'b1;
					state_d     = mrbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mrbm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_q    <= 1'b0;
			pending_q   <= '0;
			granted_q   <= '0;
			port_busy_q <= '0;
			port_q      <= '0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			for (int p = 0; p < NUM_PORTS; p++) begin
				rr_ptr_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				static_q <= cfg_data;
			end
			if (arb_start) begin
				port_q <= '0;
			end else if (arb_adv && port_q != PW'(NUM_PORTS - 1)) begin
				port_q <= port_q + PW'(1);
			end
			if (do_req) begin
				pending_q[cmd_mst] <= 1'b1;
				granted_q[cmd_mst] <= 1'b0;
			end
			if (do_grant) begin
				rr_ptr_q[port_q] <= next_ptr;
				if (sel_len == '0) begin
					pending_q[pick] <= 1'b0;
					granted_q[pick] <= 1'b0;
				end else begin
					granted_q[pick]     <= 1'b1;
					port_busy_q[port_q] <= 1'b1;
				end
			end
			if (do_beat && b_fin) begin
				port_busy_q[cmd_port] <= 1'b0;
				pending_q[b_owner]    <= 1'b0;
				granted_q[b_owner]    <= 1'b0;
			end
			if (do_grant || do_beat) begin
				hold_v_q <= 1'b1;
			end else if (hold_to_out) begin
				hold_v_q <= 1'b0;
			end
			if (hold_to_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_req) begin
			req_write_q[cmd_mst] <= q_cmd.is_write;
			req_beats_q[cmd_mst] <= q_cmd.burst_len;
		end
		if (do_grant) begin
			port_owner_q[port_q] <= pick;
			port_len_q[port_q]   <= sel_len;
			port_write_q[port_q] <= sel_wr;
			beats_done_q[port_q] <= '0;
			hold_kind_q          <= mrbm_pkg::RES_GRANT;
			hold_port_q          <= port_q;
			hold_mst_q           <= pick;
			hold_wr_q            <= sel_wr;
			hold_cnt_q           <= sel_len;
			hold_done_q          <= (sel_len == '0);
		end
		if (do_beat) begin
			beats_done_q[cmd_port] <= b_cnt[LW-1:0];
			hold_kind_q            <= mrbm_pkg::RES_BEAT;
			hold_port_q            <= cmd_port;
			hold_mst_q             <= b_owner;
			hold_wr_q              <= port_write_q[cmd_port];
			hold_cnt_q             <= b_cnt[LW-1:0];
			hold_done_q            <= b_fin;
		end
		if (hold_to_out) begin
			out_kind_q <= hold_kind_q;
			out_port_q <= hold_port_q;
			out_mst_q  <= hold_mst_q;
			out_wr_q   <= hold_wr_q;
			out_cnt_q  <= hold_cnt_q;
			out_done_q <= hold_done_q;
			out_last_q <= out_last;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.port_out    = mrbm_pkg::PORT_ID_W'(out_port_q);
	assign rsp.master_out  = mrbm_pkg::MST_ID_W'(out_mst_q);
	assign rsp.write_out   = out_wr_q;
	assign rsp.beat_count  = out_cnt_q;
	assign rsp.burst_done  = out_done_q;
	assign rsp.last_result = out_last_q;

	`MRBM_ASSERT_ALWAYS(a_granted_is_pending, (granted_q & ~pending_q) == '0, "granted master has no pending request")
	`MRBM_ASSERT_ALWAYS(a_busy_matches_granted, $countones(port_busy_q) == $countones(granted_q), "busy ports and granted masters disagree")
	`MRBM_ASSERT_IMPL(a_idle_hold_empty, state_q == mrbm_pkg::ST_IDLE, !hold_v_q, "result left behind when the sequencer went idle")

endmodule

>>> rtl/core/multiport_round_robin_burst_mux_unit.sv
// A queued command is registered in the front-end queue before the back end can pop it.
// A request item is applied when the back end pops it; a beat result passes through the hold and output registers.
// An arbitrate item holds the back end for a pop, one arbitration step per port, and a flush.
// Sustained rate: one command per back-end pass; a stalled result port stretches the pass.
// A two-entry queue lets new requests arrive while earlier commands are still at work.
// Reset: arst_n clears all requests, ports and pointers at once and selects dynamic mode.
module multiport_round_robin_burst_mux_unit #(
	parameter int NUM_MASTERS = mrbm_pkg::DEF_NUM_MASTERS,
	parameter int NUM_PORTS   = mrbm_pkg::DEF_NUM_PORTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	mrbm_cmd_if.sink    cmd,
	mrbm_rsp_if.source  rsp
);

	logic           q_valid;
	logic           q_pop;
	mrbm_pkg::cmd_t q_cmd;

	mrbm_front #(
		.NUM_MASTERS (NUM_MASTERS),
		.NUM_PORTS   (NUM_PORTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	mrbm_back #(
		.NUM_MASTERS (NUM_MASTERS),
		.NUM_PORTS   (NUM_PORTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.rsp      (rsp)
	);

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the round-robin burst mux with directed and random requests.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrbm_pkg::*;

	localparam int N_MST = DEF_NUM_MASTERS;
	localparam int N_PORT = DEF_NUM_PORTS;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] kind;
		logic [MST_ID_W-1:0]   mst;
		logic                  wr;
		logic [LEN_W-1:0]      len;
		logic [PORT_ID_W-1:0]  port;
	} mux_cmd_t;

	typedef struct packed {
		logic                  kind;
		logic [PORT_ID_W-1:0]  port;
		logic [MST_ID_W-1:0]   mst;
		logic                  wr;
		logic [LEN_W-1:0]      cnt;
		logic                  done;
		logic                  last;
	} mux_res_t;

	// n_typed: -1 takes the prediction, 0 means no result, 1 means the typed one.
	typedef struct {
		mux_cmd_t c;
		bit       map;
		int       n_typed;
		mux_res_t typed;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	mrbm_cmd_if cmd_bus();
	mrbm_rsp_if rsp_bus();

	multiport_round_robin_burst_mux_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd_bus),
		.rsp      (rsp_bus)
	);

	// Predicted arbiter state.
	bit                  static_map;
	bit [N_MST-1:0]      mst_pending;
	bit [N_MST-1:0]      mst_granted;
	bit [N_MST-1:0]      mst_write;
	logic [LEN_W-1:0]    mst_len [N_MST];
	bit [N_PORT-1:0]     port_busy;
	logic [MST_ID_W-1:0] port_owner [N_PORT];
	logic [LEN_W-1:0]    port_beats [N_PORT];
	int                  rr_next [N_PORT];

	mux_res_t step_res[$];
	mux_res_t grant_expect_q[$];
	dir_row_t dir_tab[$];

	int mismatch_cnt = 0;
	int send_idle_pct = 19;
	int rcv_idle_pct = 79;
	bit hold_go = 1'b0;
	bit rcv_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int home_port(int m);
		int f;
		f = (m >= N_MST / 2) ? m - N_MST / 2 : m;
		return (N_PORT > 1) ? f % N_PORT : 0;
	endfunction

	// Applies one request to the predicted state and leaves its results in step_res.
	function automatic void predict_mux(mux_cmd_t c);
		int m;
		int cnt;
		mux_res_t r;
		step_res.delete();
		case (c.kind)
			REQ_MASTER: begin
				if (!mst_pending[c.mst]) begin
					mst_pending[c.mst] = 1'b1;
					mst_granted[c.mst] = 1'b0;
					mst_write[c.mst] = c.wr;
					mst_len[c.mst] = c.len;
				end
			end
			REQ_ARB: begin
				for (int p = 0; p < N_PORT; p++) begin
					if (port_busy[p])
						continue;
					for (int s = 0; s < N_MST; s++) begin
						m = (rr_next[p] + s) % N_MST;
						if (!mst_pending[m] || mst_granted[m])
							continue;
						if (static_map && home_port(m) != p)
							continue;
						rr_next[p] = (m + 1) % N_MST;
						r = '0;
						r.kind = RES_GRANT;
						r.port = PORT_ID_W'(p);
						r.mst = MST_ID_W'(m);
						r.wr = mst_write[m];
						r.cnt = mst_len[m];
						if (mst_len[m] == '0) begin
							mst_pending[m] = 1'b0;
							mst_granted[m] = 1'b0;
							r.done = 1'b1;
						end else begin
							mst_granted[m] = 1'b1;
							port_busy[p] = 1'b1;
							port_owner[p] = MST_ID_W'(m);
							port_beats[p] = '0;
						end
						step_res.push_back(r);
						break;
					end
				end
				if (step_res.size() > 0)
					step_res[step_res.size() - 1].last = 1'b1;
			end
			REQ_BEAT: begin
				if (port_busy[c.port]) begin
					m = int'(port_owner[c.port]);
					cnt = int'(port_beats[c.port]) + 1;
					port_beats[c.port] = LEN_W'(cnt);
					r = '0;
					r.kind = RES_BEAT;
					r.port = c.port;
					r.mst = MST_ID_W'(m);
					r.wr = mst_write[m];
					r.cnt = LEN_W'(cnt);
					r.done = (cnt >= int'(mst_len[m]));
					r.last = 1'b1;
					if (r.done) begin
						port_busy[c.port] = 1'b0;
						mst_pending[m] = 1'b0;
						mst_granted[m] = 1'b0;
					end
					step_res.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_error(string msg);
		mismatch_cnt++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic cmp_field(string name, int got, int want);
		if (got != want)
			report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
	endtask

	task automatic check_result();
		mux_res_t got;
		mux_res_t want;
		got = {rsp_bus.result_kind, rsp_bus.port_out, rsp_bus.master_out, rsp_bus.write_out,
			rsp_bus.beat_count, rsp_bus.burst_done, rsp_bus.last_result};
		if (grant_expect_q.size() == 0) begin
			report_error($sformatf("unexpected result: kind %0d port %0d master %0d",
				got.kind, got.port, got.mst));
			return;
		end
		want = grant_expect_q.pop_front();
		cmp_field("result_kind", int'(got.kind), int'(want.kind));
		cmp_field("port_out", int'(got.port), int'(want.port));
		cmp_field("master_out", int'(got.mst), int'(want.mst));
		cmp_field("write_out", int'(got.wr), int'(want.wr));
		cmp_field("beat_count", int'(got.cnt), int'(want.cnt));
		cmp_field("burst_done", int'(got.done), int'(want.done));
		cmp_field("last_result", int'(got.last), int'(want.last));
	endtask

	// Result side: check on every handshake, then pick ready for the next edge.
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready)
				check_result();
			rsp_bus.ready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Long hold-off on the result side, so the block fills up and stalls its input.
	initial begin
		rcv_hold = 1'b0;
		wait (hold_go);
		rcv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rcv_hold <= 1'b0;
	end

	task automatic push_cmd(mux_cmd_t c, int n_typed, mux_res_t typed);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.req_type <= c.kind;
		cmd_bus.master_id <= c.mst;
		cmd_bus.is_write <= c.wr;
		cmd_bus.burst_len <= c.len;
		cmd_bus.port_id <= c.port;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		predict_mux(c);
		if (n_typed < 0) begin
			foreach (step_res[i])
				grant_expect_q.push_back(step_res[i]);
		end else if (n_typed > 0) begin
			grant_expect_q.push_back(typed);
		end
	endtask

	// Requests cause no result, so the block may still be busy when the queue empties.
	task automatic settle_idle();
		cmd_bus.valid <= 1'b0;
		while (grant_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_port_map(bit v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		static_map = v;
	endtask

	task automatic add_row(logic [REQ_TYPE_W-1:0] k, int m, bit w, int len, bit p, bit map,
		int n, mux_res_t r = '0);
		dir_row_t row;
		row.c.kind = k;
		row.c.mst = MST_ID_W'(m);
		row.c.wr = w;
		row.c.len = LEN_W'(len);
		row.c.port = p;
		row.map = map;
		row.n_typed = n;
		row.typed = r;
		dir_tab.push_back(row);
	endtask

	function automatic mux_cmd_t rand_cmd();
		mux_cmd_t c;
		int r;
		int sel;
		c.mst = MST_ID_W'($urandom_range(N_MST - 1));
		c.wr = 1'($urandom_range(1));
		c.len = LEN_W'($urandom);
		c.port = PORT_ID_W'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 4) begin
			c.kind = REQ_UNUSED;
		end else if (r < 40) begin
			c.kind = REQ_MASTER;
			sel = $urandom_range(99);
			if (sel < 70)
				c.len = LEN_W'($urandom_range(3));
			else if (sel < 98)
				c.len = LEN_W'($urandom_range(12, 4));
			else
				c.len = LEN_W'($urandom_range(255, 13));
		end else if (r < 60) begin
			c.kind = REQ_ARB;
		end else begin
			c.kind = REQ_BEAT;
			// Mostly aim beats at a busy port so bursts actually complete.
			if (port_busy != '0 && $urandom_range(9) != 0) begin
				do
					c.port = PORT_ID_W'($urandom_range(N_PORT - 1));
				while (!port_busy[c.port]);
			end
		end
		return c;
	endfunction

	task automatic run_random(int s_idle, int r_idle, bit map, int n, int hold_at);
		settle_idle();
		set_port_map(map);
		send_idle_pct = s_idle;
		rcv_idle_pct = r_idle;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_go = 1'b1;
			push_cmd(rand_cmd(), -1, '0);
		end
	endtask

	initial begin
		mux_cmd_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.req_type = REQ_MASTER;
		cmd_bus.master_id = '0;
		cmd_bus.is_write = 1'b0;
		cmd_bus.burst_len = '0;
		cmd_bus.port_id = '0;
		static_map = 1'b0;
		foreach (mst_len[i])
			mst_len[i] = '0;
		foreach (port_owner[i]) begin
			port_owner[i] = '0;
			port_beats[i] = '0;
			rr_next[i] = 0;
		end

		// Empty block: beats on free ports, an idle arbitration pass, the unused type.
		add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0);
		add_row(REQ_BEAT, 7, 1, 255, 1, 0, 0);
		add_row(REQ_ARB, 0, 0, 0, 0, 0, 0);
		add_row(REQ_UNUSED, 5, 1, 170, 1, 0, 0);
		// Zero-length burst frees the port at the grant.
		add_row(REQ_MASTER, 0, 1, 0, 0, 0, 0);
		add_row(REQ_ARB, 0, 0, 0, 0, 0, 1, '{RES_GRANT, 1'b0, 3'd0, 1'b1, 8'd0, 1'b1, 1'b1});
		// Longest burst, then a duplicate request from the same master that must be dropped.
		add_row(REQ_MASTER, 7, 0, 255, 0, 0, 0);
		add_row(REQ_MASTER, 7, 1, 3, 1, 0, 0);
		add_row(REQ_ARB, 0, 0, 0, 0, 0, 1, '{RES_GRANT, 1'b0, 3'd7, 1'b0, 8'd255, 1'b0, 1'b1});
		add_row(REQ_MASTER, 3, 1, 1, 0, 0, 0);
		add_row(REQ_MASTER, 4, 0, 2, 1, 0, 0);
		add_row(REQ_ARB, 0, 0, 0, 0, 0, 1, '{RES_GRANT, 1'b1, 3'd3, 1'b1, 8'd1, 1'b0, 1'b1});
		add_row(REQ_BEAT, 0, 0, 0, 1, 0, 1, '{RES_BEAT, 1'b1, 3'd3, 1'b1, 8'd1, 1'b1, 1'b1});
		add_row(REQ_ARB, 0, 0, 0, 0, 0, -1);
		add_row(REQ_BEAT, 0, 0, 0, 1, 0, -1);
		add_row(REQ_BEAT, 0, 0, 0, 1, 0, -1);
		add_row(REQ_BEAT, 0, 0, 0, 0, 0, -1);
		// Static mapping; master 2 waits on its busy home port.
		add_row(REQ_MASTER, 5, 1, 2, 0, 1, 0);
		add_row(REQ_MASTER, 2, 0, 4, 0, 1, 0);
		add_row(REQ_MASTER, 3, 1, 0, 0, 1, 0);
		add_row(REQ_ARB, 0, 0, 0, 0, 1, -1);
		add_row(REQ_BEAT, 0, 0, 0, 1, 1, -1);
		add_row(REQ_BEAT, 0, 0, 0, 1, 1, -1);
		add_row(REQ_ARB, 0, 0, 0, 0, 1, -1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_port_map(1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].map != static_map) begin
				settle_idle();
				set_port_map(dir_tab[i].map);
			end
			push_cmd(dir_tab[i].c, dir_tab[i].n_typed, dir_tab[i].typed);
		end

		// Run the long burst to its end.
		while (port_busy != '0) begin
			c = rand_cmd();
			c.kind = REQ_BEAT;
			c.port = port_busy[0] ? 1'b0 : 1'b1;
			push_cmd(c, -1, '0);
		end

		run_random(19, 79, 1'b1, 45, -1);
		run_random(79, 19, 1'b0, 45, -1);
		run_random(0, 0, 1'b1, 50, 30);

		settle_idle();
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/mrbm_pkg.sv
rtl/core/mrbm_cmd_if.sv
rtl/core/mrbm_rsp_if.sv
rtl/core/mrbm_front.sv
rtl/core/mrbm_back.sv
rtl/core/multiport_round_robin_burst_mux_unit.sv
tb/sv/tb_top.sv
